@@ hw/rtl/tlsr_pkg.sv @@
// Shared types and constants for the three-generator shuffled random source.
// Holds the sequencer states, the modular unit's operation record and the
// generator constants. No dependencies.
package tlsr_pkg;

  localparam logic [17:0] MOD_A = 18'd259200;
  localparam logic [12:0] MUL_A = 13'd7141;
  localparam logic [15:0] ADD_A = 16'd54773;
  localparam logic [17:0] MOD_B = 18'd134456;
  localparam logic [12:0] MUL_B = 13'd8121;
  localparam logic [15:0] ADD_B = 16'd28411;
  localparam logic [17:0] MOD_C = 18'd243000;
  localparam logic [12:0] MUL_C = 13'd4561;
  localparam logic [15:0] ADD_C = 16'd51349;

  localparam int RECIP_SHIFT = 47;
  localparam logic [29:0] RECIP_A = 30'((64'd1 << RECIP_SHIFT) / 64'd259200);
  localparam logic [29:0] RECIP_B = 30'((64'd1 << RECIP_SHIFT) / 64'd134456);
  localparam logic [29:0] RECIP_C = 30'((64'd1 << RECIP_SHIFT) / 64'd243000);

  localparam logic [31:0] SEED_OFFSET = 32'(64'd259200 * 64'd8286);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED,
    ST_G1A,
    ST_G2INIT,
    ST_G1B,
    ST_GPINIT,
    ST_FILL_A,
    ST_FILL_B,
    ST_FILL_W,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_DRAW_C,
    ST_SLOT,
    ST_READ,
    ST_SWAP,
    ST_PUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_G1,
    SRC_G2,
    SRC_GP,
    SRC_SEED
  } src_t;

  typedef enum logic [1:0] {
    DST_G1,
    DST_G2,
    DST_GP,
    DST_SLOT
  } dst_t;

  typedef struct packed {
    logic        active;
    logic [12:0] mul;
    logic [15:0] add;
    logic [17:0] modulus;
    logic [29:0] recip;
    src_t        src;
    dst_t        dst;
  } unit_op_t;

endpackage

@@ hw/rtl/three_lcg_shuffled_random_top.sv @@
// Top level of the three-generator shuffled random source.
// Uses tlsr_pkg for states and constants and tlsr_ram for the shuffle table.
//
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_we               cfg_seed (signed 32)
// in       in         in_valid / in_stall  in_reseed (1)
// out      out        out_valid / out_stall out_value_numerator (36)
//
// All generator updates and the slot index go through one shared modular unit
// that works each operation as multiply-add, reciprocal multiply,
// back-multiply and correct, in that order. The block returns to idle, and can
// take the next request, in the same cycle in which out_valid rises.
// A draw that first seeds the generators also fills the whole shuffle table.
// Synchronous reset clears the control state and sets the seed to -1.
// A result waiting on out_stall holds the sequencer, but the block accepts a
// new request while an earlier result still sits in the output register.
module three_lcg_shuffled_random_top #(
  parameter int TABLE_DEPTH = 97
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_seed,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_reseed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [35:0]        out_value_numerator
);
  import tlsr_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t state_r, state_nxt;
  logic [1:0]  ph_r;
  logic        ph_last;
  unit_op_t    op;

  logic signed [31:0] seed_r;
  logic        init_r;
  logic [17:0] g1_r, g2_r, gp_r;
  logic [IDX_W-1:0] slot_r, fill_cnt_r;
  logic [31:0] p_r;
  logic [61:0] prod_r;
  logic [14:0] q_r;
  logic [31:0] qn_r;
  logic [35:0] drawn_r, out_value_r;
  logic        out_valid_r;

  logic        accept, fill_last, out_free;
  logic [17:0] src_x;
  logic signed [33:0] seed_d;
  logic [31:0] p_seed, p_nxt;
  logic [32:0] qn_full;
  logic [18:0] rem_raw;
  logic [17:0] res;
  logic [14:0] q_fix;
  logic [IDX_W-1:0] slot_fix;
  logic [35:0] comb_w;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [35:0]      ram_rdata;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign ph_last   = (ph_r == 2'd3);
  assign fill_last = (fill_cnt_r == IDX_W'(TABLE_DEPTH - 1));
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_reseed || !init_r) ? ST_SEED : ST_DRAW_A;
        end
      end
      ST_SEED:   if (ph_last) state_nxt = ST_G1A;
      ST_G1A:    if (ph_last) state_nxt = ST_G2INIT;
      ST_G2INIT: if (ph_last) state_nxt = ST_G1B;
      ST_G1B:    if (ph_last) state_nxt = ST_GPINIT;
      ST_GPINIT: if (ph_last) state_nxt = ST_FILL_A;
      ST_FILL_A: if (ph_last) state_nxt = ST_FILL_B;
      ST_FILL_B: if (ph_last) state_nxt = ST_FILL_W;
      ST_FILL_W: state_nxt = fill_last ? ST_DRAW_A : ST_FILL_A;
      ST_DRAW_A: if (ph_last) state_nxt = ST_DRAW_B;
      ST_DRAW_B: if (ph_last) state_nxt = ST_DRAW_C;
      ST_DRAW_C: if (ph_last) state_nxt = ST_SLOT;
      ST_SLOT:   if (ph_last) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SWAP;
      ST_SWAP:   state_nxt = ST_PUT;
      ST_PUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op         = '0;
    op.src     = SRC_G1;
    op.dst     = DST_G1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = slot_r;
    case (state_r)
      ST_SEED: begin
        op.active  = 1'b1;
        op.modulus = MOD_A;
        op.recip   = RECIP_A;
        op.src     = SRC_SEED;
      end
      ST_G1A, ST_G1B, ST_FILL_A, ST_DRAW_A: begin
        op.active  = 1'b1;
        op.mul     = MUL_A;
        op.add     = ADD_A;
        op.modulus = MOD_A;
        op.recip   = RECIP_A;
      end
      ST_G2INIT: begin
        op.active  = 1'b1;
        op.mul     = 13'd1;
        op.modulus = MOD_B;
        op.recip   = RECIP_B;
        op.dst     = DST_G2;
      end
      ST_GPINIT: begin
        op.active  = 1'b1;
        op.mul     = 13'd1;
        op.modulus = MOD_C;
        op.recip   = RECIP_C;
        op.dst     = DST_GP;
      end
      ST_FILL_B, ST_DRAW_B: begin
        op.active  = 1'b1;
        op.mul     = MUL_B;
        op.add     = ADD_B;
        op.modulus = MOD_B;
        op.recip   = RECIP_B;
        op.src     = SRC_G2;
        op.dst     = DST_G2;
      end
      ST_DRAW_C: begin
        op.active  = 1'b1;
        op.mul     = MUL_C;
        op.add     = ADD_C;
        op.modulus = MOD_C;
        op.recip   = RECIP_C;
        op.src     = SRC_GP;
        op.dst     = DST_GP;
      end
      ST_SLOT: begin
        op.active  = 1'b1;
        op.mul     = 13'(TABLE_DEPTH);
        op.modulus = MOD_C;
        op.recip   = RECIP_C;
        op.src     = SRC_GP;
        op.dst     = DST_SLOT;
      end
      ST_FILL_W: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt_r;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_SWAP: begin
        ram_we = 1'b1;
      end
      default: begin
        op.active = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (op.src)
      SRC_G2:  src_x = g2_r;
      SRC_GP:  src_x = gp_r;
      default: src_x = g1_r;
    endcase
  end

  assign seed_d  = 34'sd54773 - 34'(seed_r);
  assign p_seed  = seed_d[33] ? 32'(seed_d + $signed({2'b00, SEED_OFFSET})) : seed_d[31:0];
  assign p_nxt   = (op.src == SRC_SEED) ? p_seed
                 : (32'(op.mul) * 32'(src_x) + 32'(op.add));
  assign qn_full = 33'(prod_r[61:RECIP_SHIFT]) * 33'(op.modulus);
  assign rem_raw = 19'(p_r - qn_r);

  always_comb begin
    if (rem_raw >= 19'(op.modulus)) begin
      res   = 18'(rem_raw - 19'(op.modulus));
      q_fix = q_r + 15'd1;
    end else begin
      res   = rem_raw[17:0];
      q_fix = q_r;
    end
    if (q_fix >= 15'(TABLE_DEPTH)) begin
      slot_fix = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      slot_fix = q_fix[IDX_W-1:0];
    end
  end

  assign comb_w = 36'(g1_r) * 36'(MOD_B) + 36'(g2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 2'd0;
      seed_r      <= -32'sd1;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fill_cnt_r  <= '0;
      g1_r        <= '0;
      g2_r        <= '0;
      gp_r        <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= op.active ? ph_r + 2'd1 : 2'd0;
      if (cfg_we) begin
        seed_r <= cfg_seed;
      end
      if (state_r == ST_SEED) begin
        fill_cnt_r <= '0;
      end else if (state_r == ST_FILL_W) begin
        fill_cnt_r <= fill_cnt_r + IDX_W'(1);
        if (fill_last) begin
          init_r <= 1'b1;
        end
      end
      if (op.active && ph_last) begin
        case (op.dst)
          DST_G1:  g1_r <= res;
          DST_G2:  g2_r <= res;
          DST_GP:  gp_r <= res;
          default: g1_r <= g1_r;
        endcase
      end
      if (state_r == ST_PUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.active && ph_r == 2'd0) begin
      p_r <= p_nxt;
    end
    prod_r <= 62'(p_r) * 62'(op.recip);
    q_r    <= prod_r[61:RECIP_SHIFT];
    qn_r   <= qn_full[31:0];
    if (op.active && ph_last && op.dst == DST_SLOT) begin
      slot_r <= slot_fix;
    end
    if (state_r == ST_SWAP) begin
      drawn_r <= ram_rdata;
    end
    if (state_r == ST_PUT && out_free) begin
      out_value_r <= drawn_r;
    end
  end

  tlsr_ram #(
    .WIDTH(36),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (comb_w),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_value_numerator = out_value_r;

endmodule

@@ hw/rtl/tlsr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the shuffle table. Depends on nothing.
module tlsr_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 97
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tlsr_checker.sv @@
// Port-level checker for the three-generator shuffled random source.
// Watches only the top level's ports; bound to three_lcg_shuffled_random_top.
module tlsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [35:0] out_value_numerator
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_numerator))
    else $error("Stalled result changed or vanished.");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value_numerator < 36'd34850995200)
    else $error("Result numerator out of range.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Block ready right after an input transfer.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared while the block was idle.");

endmodule

bind three_lcg_shuffled_random_top tlsr_checker u_tlsr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_value_numerator (out_value_numerator)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for three_lcg_shuffled_random_top: predicts every draw from its own
// copy of the three generators and the shuffle table. Depends on tlsr_pkg and the RTL only.
module tb_top;
  import tlsr_pkg::*;

  localparam int SLOTS = 97;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 14;
  localparam int DRAWS_PER_PHASE = 50;

  typedef struct packed {
    logic        set_seed;
    logic [31:0] seed;
    logic        reseed;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [21] = '{
    '{1'b0, 32'sd0, 1'b0},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b0, 32'sd0, 1'b1},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b1, 32'sd54773, 1'b0},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b0, 32'sd0, 1'b1},
    '{1'b1, -32'sd2147483647, 1'b1},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b1, 32'h80000000, 1'b1},
    '{1'b1, 32'h7FFFFFFF, 1'b1},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b1, 32'sd0, 1'b1},
    '{1'b1, 32'sd54774, 1'b1},
    '{1'b1, -32'sd204427, 1'b1},
    '{1'b0, 32'sd0, 1'b1},
    '{1'b0, 32'sd0, 1'b1},
    '{1'b0, 32'sd0, 1'b0},
    '{1'b1, -32'sd1, 1'b1},
    '{1'b0, 32'sd0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic signed [31:0] cfg_seed = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_reseed = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [35:0]        out_value_numerator;

  logic signed [31:0] seed_reg;
  logic [17:0]        lcg_one;
  logic [17:0]        lcg_two;
  logic [17:0]        lcg_pick;
  logic [35:0]        shuffle_slots [SLOTS];
  logic               primed;

  logic [35:0] pending_values [$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  three_lcg_shuffled_random_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_seed            (cfg_seed),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_reseed           (in_reseed),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value_numerator (out_value_numerator)
  );

  always #5 clk = ~clk;

  function automatic logic [17:0] lcg_next(input logic [17:0] x, input logic [12:0] mul,
                                           input logic [15:0] add, input logic [17:0] modulus);
    logic [63:0] acc;
    acc = 64'(mul) * 64'(x) + 64'(add);
    return 18'(acc % 64'(modulus));
  endfunction

  function automatic logic [35:0] mixed_entry();
    return 36'(64'(lcg_one) * 64'(MOD_B) + 64'(lcg_two));
  endfunction

  function automatic void seed_generators();
    longint start;
    start = (longint'(ADD_A) - longint'(seed_reg)) % longint'(MOD_A);
    if (start < 0) start += longint'(MOD_A);
    lcg_one = lcg_next(18'(start), MUL_A, ADD_A, MOD_A);
    lcg_two = 18'(lcg_one % MOD_B);
    lcg_one = lcg_next(lcg_one, MUL_A, ADD_A, MOD_A);
    lcg_pick = 18'(lcg_one % MOD_C);
    for (int k = 0; k < SLOTS; k++) begin
      lcg_one = lcg_next(lcg_one, MUL_A, ADD_A, MOD_A);
      lcg_two = lcg_next(lcg_two, MUL_B, ADD_B, MOD_B);
      shuffle_slots[k] = mixed_entry();
    end
    primed = 1'b1;
  endfunction

  function automatic logic [35:0] predict_draw(input logic reseed);
    logic [63:0] slot;
    logic [35:0] drawn;
    if (reseed || !primed) seed_generators();
    lcg_one = lcg_next(lcg_one, MUL_A, ADD_A, MOD_A);
    lcg_two = lcg_next(lcg_two, MUL_B, ADD_B, MOD_B);
    lcg_pick = lcg_next(lcg_pick, MUL_C, ADD_C, MOD_C);
    slot = 64'(SLOTS) * 64'(lcg_pick) / 64'(MOD_C);
    if (slot >= SLOTS) slot = SLOTS - 1;
    drawn = shuffle_slots[slot];
    shuffle_slots[slot] = mixed_entry();
    return drawn;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    bit moved;
    logic [35:0] want;
    moved = 1'b0;
    if (!rst_n) begin
      seed_reg = -32'sd1;
      lcg_one = '0;
      lcg_two = '0;
      lcg_pick = '0;
      primed = 1'b0;
      pending_values.delete();
    end else begin
      if (cfg_we) begin
        seed_reg = cfg_seed;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_values.size() == 0) begin
          $display("%0t: unexpected result, value_numerator %0d", $time, out_value_numerator);
          errors++;
        end else begin
          want = pending_values.pop_front();
          if (out_value_numerator !== want) begin
            $display("%0t: value_numerator expected %0d, actual %0d", $time, want,
                     out_value_numerator);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_values.push_back(predict_draw(in_reseed));
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    int hold;
    forever begin
      hold = gap_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(input logic reseed);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_reseed <= reseed;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_seed <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] next_seed;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].set_seed) write_seed(DIRECTED_ROWS[i].seed);
      send_request(DIRECTED_ROWS[i].reseed);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase % 4 == 3);
      case ($urandom_range(0, 4))
        0: next_seed = $urandom;
        1: next_seed = $urandom_range(0, 54773);
        2: next_seed = ~$urandom_range(0, 32'h7FFFFFFE);
        3: next_seed = 32'sd54773;
        default: next_seed = -32'sd2147483647;
      endcase
      write_seed(next_seed);
      for (int k = 0; k < DRAWS_PER_PHASE; k++)
        send_request(k == 0 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) < 4));
    end

    no_idle = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_values.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
